/* rtl/ght_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ght_pkg
// Shared types, codes and helpers for the generation-counted handle table.
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int SLOT_COUNT = 1024;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int WORD_BITS  = 32;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int BM_WORDS   = SLOT_COUNT / WORD_BITS;
  localparam int BMW_W      = $clog2(BM_WORDS);
  localparam int SIZE_W     = 11;
  localparam int GEN_W      = 32;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_NOMEM     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND  = 3'd3;
  localparam logic [2:0] ST_WRONGTYPE = 3'd4;

  // request modes
  localparam logic [1:0] MODE_ALLOC  = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_REVOKE = 2'd2;

  // command kinds after classification
  localparam logic [1:0] KIND_REPLY  = 2'd0;
  localparam logic [1:0] KIND_ALLOC  = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;
  localparam logic [1:0] KIND_REVOKE = 2'd3;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] slot_index;
    logic [31:0] handle_generation;
    logic [63:0] object_word;
    logic [31:0] object_type;
    logic [63:0] access_rights;
  } item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] result_index;
    logic [31:0]       result_generation;
    logic [63:0]       found_object;
    logic [63:0]       found_rights;
    logic [SIZE_W-1:0] live_count;
  } result_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  gen;
    logic [63:0]       obj;
    logic [31:0]       typ;
    logic [63:0]       rights;
    logic [SIZE_W-1:0] usable;
  } cmd_t;

  function automatic logic [BIT_W-1:0] first_set_word(input logic [WORD_BITS-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  function automatic logic [BMW_W-1:0] first_set_map(input logic [BM_WORDS-1:0] v);
    logic [BMW_W-1:0] r;
    r = '0;
    for (int i = BM_WORDS - 1; i >= 0; i--) begin
      if (v[i]) r = BMW_W'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* rtl/ght_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ght_front
// Holds the table size register and classifies each request into a command:
// an immediate reply, or an allocate, lookup or revoke for the back end.
// ----------------------------------------------------------------------------
module ght_front import ght_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [SIZE_W-1:0] cfg_data,
  input  wire item_t             item,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              q_full,
  input  wire logic              busy,
  output logic                   q_push,
  output cmd_t                   cmd
);

  logic [SIZE_W-1:0] table_size;
  logic [SIZE_W-1:0] usable;
  logic              idx_bad;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_W'(SLOT_COUNT);
    end else if (cfg_valid) begin
      table_size <= cfg_data;
    end
  end

  assign usable  = (table_size > SIZE_W'(SLOT_COUNT)) ? SIZE_W'(SLOT_COUNT) : table_size;
  assign idx_bad = item.slot_index >= 16'(usable);

  assign full   = q_full | busy;
  assign q_push = push & ~full;

  always_comb begin
    cmd        = '0;
    cmd.slot   = item.slot_index[SLOT_W-1:0];
    cmd.gen    = item.handle_generation;
    cmd.obj    = item.object_word;
    cmd.typ    = item.object_type;
    cmd.rights = item.access_rights;
    cmd.usable = usable;
    cmd.kind   = KIND_REPLY;
    cmd.status = ST_INVALID;
    case (item.mode)
      MODE_ALLOC: begin
        if (item.object_word == 64'd0) begin
          cmd.status = ST_INVALID;
        end else if (usable == '0) begin
          cmd.status = ST_NOMEM;
        end else begin
          cmd.kind = KIND_ALLOC;
        end
      end
      MODE_LOOKUP: begin
        if (!idx_bad) cmd.kind = KIND_LOOKUP;
      end
      MODE_REVOKE: begin
        if (!idx_bad) cmd.kind = KIND_REVOKE;
      end
      default: begin
        cmd.kind   = KIND_REPLY;
        cmd.status = ST_INVALID;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/ght_cmd_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ght_cmd_fifo
// Two-entry command queue between the classifier and the table engine.
// ----------------------------------------------------------------------------
module ght_cmd_fifo import ght_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire cmd_t wr_data,
  output logic      full,
  output logic      valid,
  input  wire logic rd_en,
  output cmd_t      rd_data
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = count == 2'd2;
  assign valid   = count != 2'd0;
  assign rd_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) entry[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/ght_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ght_engine
// Table engine: slot memories, free bitmap with a word summary, live count,
// the sequencer that carries out commands, and the result register.
// ----------------------------------------------------------------------------
module ght_engine import ght_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire cmd_t q_cmd,
  output logic      q_pop,
  output logic      busy,
  output logic      empty,
  input  wire logic pop,
  output result_t   result
);

  typedef struct packed {
    logic             active;
    logic [GEN_W-1:0] gen;
  } meta_t;

  typedef struct packed {
    logic [31:0] typ;
    logic [63:0] obj;
    logic [63:0] rights;
  } pay_t;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_BITS  = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]           state;
  logic [SLOT_W-1:0]    sweep;
  cmd_t                 cur;
  logic [BMW_W-1:0]     word_sel;
  logic [BM_WORDS-1:0]  summary;   // 1: word still has a free slot
  logic [SIZE_W-1:0]    count;
  result_t              res;
  logic                 out_valid;

  meta_t                meta_mem [SLOT_COUNT];
  pay_t                 pay_mem  [SLOT_COUNT];
  logic [WORD_BITS-1:0] bm_mem   [BM_WORDS];
  meta_t                meta_q;
  pay_t                 pay_q;
  logic [WORD_BITS-1:0] bm_q;

  logic                 meta_we, meta_re, pay_we, bm_we, bm_re;
  logic [SLOT_W-1:0]    meta_wa, meta_ra;
  meta_t                meta_wd;
  logic [BMW_W-1:0]     bm_wa, bm_ra;
  logic [WORD_BITS-1:0] bm_wd;

  logic [BIT_W-1:0]     new_bit;
  logic [SLOT_W-1:0]    new_slot;
  logic [WORD_BITS-1:0] new_mask;
  logic [WORD_BITS-1:0] cur_mask;
  logic                 new_fits;
  logic                 match;
  logic [GEN_W-1:0]     gen_inc;
  logic                 out_load;
  logic [2:0]           idle_status;

  assign new_bit  = first_set_word(~bm_q);
  assign new_slot = {word_sel, new_bit};
  assign new_mask = WORD_BITS'(1) << new_bit;
  assign new_fits = SIZE_W'(new_slot) < cur.usable;
  assign cur_mask = WORD_BITS'(1) << cur.slot[BIT_W-1:0];
  assign match    = meta_q.active && (meta_q.gen == cur.gen);
  assign gen_inc  = meta_q.gen + GEN_W'(1);

  // allocate with no free word ends as no memory; other kinds set status later
  assign idle_status = (q_cmd.kind == KIND_REPLY) ? q_cmd.status : ST_NOMEM;

  assign busy     = state == S_CLEAR;
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign out_load = (state == S_DONE) && (!out_valid || pop);
  assign empty    = ~out_valid;

  // memory port control
  always_comb begin
    meta_we = 1'b0;
    meta_wa = cur.slot;
    meta_wd = '0;
    meta_re = 1'b0;
    meta_ra = q_cmd.slot;
    pay_we  = 1'b0;
    bm_we   = 1'b0;
    bm_wa   = word_sel;
    bm_wd   = '0;
    bm_re   = 1'b0;
    bm_ra   = first_set_map(summary);
    case (state)
      S_CLEAR: begin
        meta_we = 1'b1;
        meta_wa = sweep;
        bm_we   = 1'b1;
        bm_wa   = sweep[BMW_W-1:0];
      end
      S_IDLE: begin
        if (q_valid) begin
          case (q_cmd.kind)
            KIND_ALLOC:  bm_re = summary != '0;
            KIND_LOOKUP: meta_re = 1'b1;
            KIND_REVOKE: begin
              meta_re = 1'b1;
              bm_re   = 1'b1;
              bm_ra   = q_cmd.slot[SLOT_W-1:BIT_W];
            end
            default: ;
          endcase
        end
      end
      S_BITS: begin
        if (new_fits) begin
          bm_we   = 1'b1;
          bm_wd   = bm_q | new_mask;
          meta_re = 1'b1;
          meta_ra = new_slot;
        end
      end
      S_EXEC: begin
        case (cur.kind)
          KIND_ALLOC: begin
            meta_we = 1'b1;
            meta_wd = '{active: 1'b1, gen: gen_inc};
            pay_we  = 1'b1;
          end
          KIND_REVOKE: begin
            if (match) begin
              meta_we = 1'b1;
              meta_wd = '{active: 1'b0, gen: meta_q.gen};
              bm_we   = 1'b1;
              bm_wa   = cur.slot[SLOT_W-1:BIT_W];
              bm_wd   = bm_q & ~cur_mask;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[meta_wa] <= meta_wd;
    if (meta_re) meta_q <= meta_mem[meta_ra];
  end

  always_ff @(posedge clk) begin
    if (pay_we) pay_mem[cur.slot] <= '{typ: cur.typ, obj: cur.obj, rights: cur.rights};
    if (meta_re) pay_q <= pay_mem[meta_ra];
  end

  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_wa] <= bm_wd;
    if (bm_re) bm_q <= bm_mem[bm_ra];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      sweep   <= '0;
      summary <= '1;
      count   <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          sweep <= sweep + SLOT_W'(1);
          if (sweep == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            cur      <= q_cmd;
            word_sel <= first_set_map(summary);
            res      <= '{status: idle_status, result_index: '0, result_generation: '0,
                          found_object: '0, found_rights: '0, live_count: count};
            case (q_cmd.kind)
              KIND_REPLY: state <= S_DONE;
              KIND_ALLOC: state <= (summary == '0) ? S_DONE : S_BITS;
              default:    state <= S_EXEC;
            endcase
          end
        end
        S_BITS: begin
          if (new_fits) begin
            summary[word_sel] <= ~&(bm_q | new_mask);
            cur.slot          <= new_slot;
            state             <= S_EXEC;
          end else begin
            res.status <= ST_NOMEM;
            state      <= S_DONE;
          end
        end
        S_EXEC: begin
          case (cur.kind)
            KIND_ALLOC: begin
              count                 <= count + SIZE_W'(1);
              res.status            <= ST_OK;
              res.result_index      <= cur.slot;
              res.result_generation <= gen_inc;
              res.live_count        <= count + SIZE_W'(1);
            end
            KIND_LOOKUP: begin
              if (!match) begin
                res.status <= ST_NOTFOUND;
              end else if (cur.typ != 32'd0 && pay_q.typ != cur.typ) begin
                res.status <= ST_WRONGTYPE;
              end else begin
                res.status       <= ST_OK;
                res.found_object <= pay_q.obj;
                res.found_rights <= pay_q.rights;
              end
            end
            default: begin
              if (match) begin
                summary[cur.slot[SLOT_W-1:BIT_W]] <= 1'b1;
                res.status <= ST_OK;
                if (count != '0) begin
                  count          <= count - SIZE_W'(1);
                  res.live_count <= count - SIZE_W'(1);
                end
              end else begin
                res.status <= ST_NOTFOUND;
              end
            end
          endcase
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) result <= res;
  end

endmodule
`default_nettype wire

/* rtl/generation_handle_table_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// generation_handle_table_top
// Generation-counted handle table with allocate, lookup/validate and revoke.
//
// Request side is a queue: a beat is taken when push is high and full low.
// Result side is a queue: the oldest result sits on result while empty is
// low and leaves on a beat with pop high. One result per request, in order.
// cfg_data writes the table size whenever cfg_valid is high (cfg_ready is
// always high); write it only while no request is in flight.
// Requests go into a two-entry command queue, so pushing continues while a
// finished result waits to be popped. The engine then serves one command at
// a time: a request rejected at classification goes straight to the result
// register; a lookup or revoke reads the slot memory, then executes; an
// allocate reads a free-bitmap word, then claims a slot and reads its entry,
// then writes it. After reset the engine sweeps the whole slot memory,
// holding full high. If result is not popped the engine holds its next
// result and full rises once the command queue fills.
// ----------------------------------------------------------------------------
module generation_handle_table_top import ght_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [SIZE_W-1:0] cfg_data,
  input  wire item_t             item,
  input  wire logic              push,
  output logic                   full,
  output result_t                result,
  output logic                   empty,
  input  wire logic              pop
);

  logic q_full, q_push, q_valid, q_pop, busy;
  cmd_t wr_cmd, rd_cmd;

  ght_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .item      (item),
    .push      (push),
    .full      (full),
    .q_full    (q_full),
    .busy      (busy),
    .q_push    (q_push),
    .cmd       (wr_cmd)
  );

  ght_cmd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (wr_cmd),
    .full    (q_full),
    .valid   (q_valid),
    .rd_en   (q_pop),
    .rd_data (rd_cmd)
  );

  ght_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_cmd   (rd_cmd),
    .q_pop   (q_pop),
    .busy    (busy),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

endmodule
`default_nettype wire
